// ----- rtl/tue_pkg.sv -----
// Shared types and constants for the tetrahedron unique edge extractor.
// Used by every module of the block; depends on nothing.
package tue_pkg;

  localparam int FIELD_W = 16;
  localparam int NUM_W = 14;
  localparam int EPOCH_W = 4;
  localparam int NUM_PAIRS = 6;
  localparam int HASH_LAT = 3;

  localparam logic STATUS_STORED = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  typedef logic [2:0] pair_idx_t;

  typedef struct packed {
    logic accept;
    logic sweep;
    logic first_pair;
    logic next_pair;
    logic step;
    logic insert;
    logic drop;
    logic flush;
  } tue_cmd_t;

  typedef struct packed {
    logic need_sweep;
    logic sweep_last;
    logic occupied;
    logic match;
    logic last_probe;
    logic last_pair;
    logic res_ok;
    logic pend_valid;
  } tue_sts_t;

endpackage

// ----- rtl/tetra_unique_edge_extractor.sv -----
// Top level of the tetrahedron unique edge extractor: controller plus datapath.
// Depends on tue_pkg, tue_ctrl, tue_dpath, tue_hash.
//
//   Channel  Handshake              Beat contents
//   tet      tet_valid/tet_stall    corner_a..corner_d, clear_table
//   edge     edge_valid/edge_stall  edge_first, edge_second, edge_number, status, last_of_item
//
// The block takes no new item until all six pairs of the current one have resolved; each
// further probe of a pair passes through a read state and a check state again, since the
// read of the edge slot memory is registered.
// After reset a clearing pass over all TABLE_DEPTH slots runs before the first item is taken;
// every fifteenth clear_table repeats that pass.
// A stalled edge channel holds the block once two results wait and a third is ready.
module tetra_unique_edge_extractor import tue_pkg::*; #(
  parameter int VERTEX_BITS = 16,
  parameter int TABLE_DEPTH = 16384,
  parameter int PROBE_LIMIT = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               tet_valid,
  output logic               tet_stall,
  input  logic [FIELD_W-1:0] corner_a,
  input  logic [FIELD_W-1:0] corner_b,
  input  logic [FIELD_W-1:0] corner_c,
  input  logic [FIELD_W-1:0] corner_d,
  input  logic               clear_table,
  output logic               edge_valid,
  input  logic               edge_stall,
  output logic [FIELD_W-1:0] edge_first,
  output logic [FIELD_W-1:0] edge_second,
  output logic [NUM_W-1:0]   edge_number,
  output logic               status,
  output logic               last_of_item
);

  tue_cmd_t cmd;
  tue_sts_t sts;

  tue_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .tet_valid(tet_valid),
    .tet_stall(tet_stall),
    .sts(sts),
    .cmd(cmd)
  );

  tue_dpath #(
    .VERTEX_BITS(VERTEX_BITS),
    .TABLE_DEPTH(TABLE_DEPTH),
    .PROBE_LIMIT(PROBE_LIMIT)
  ) u_dpath (
    .clk(clk),
    .rst(rst),
    .corner_a(corner_a),
    .corner_b(corner_b),
    .corner_c(corner_c),
    .corner_d(corner_d),
    .clear_table(clear_table),
    .cmd(cmd),
    .sts(sts),
    .edge_valid(edge_valid),
    .edge_stall(edge_stall),
    .edge_first(edge_first),
    .edge_second(edge_second),
    .edge_number(edge_number),
    .status(status),
    .last_of_item(last_of_item)
  );

endmodule

// ----- rtl/tue_hash.sv -----
// Three-stage home slot unit: (first XOR second) modulo the table depth.
// The remainder uses a constant reciprocal multiply; depends on tue_pkg.
module tue_hash import tue_pkg::*; #(
  parameter int VERT_W = 16,
  parameter int TABLE_DEPTH = 16384
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  pair_idx_t                        in_tag,
  input  logic [VERT_W-1:0]                in_x,
  output logic                             out_valid,
  output pair_idx_t                        out_tag,
  output logic [$clog2(TABLE_DEPTH)-1:0]   out_home
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int DW = $clog2(TABLE_DEPTH + 1);
  localparam int SHIFT = VERT_W + AW;
  localparam int RECIP_W = VERT_W + 2;
  localparam int PW1 = VERT_W + RECIP_W;
  localparam int PW2 = VERT_W + DW;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
  localparam logic [DW-1:0] DEPTH = DW'(TABLE_DEPTH);

  logic              s1_valid;
  logic              s2_valid;
  pair_idx_t         s1_tag;
  pair_idx_t         s2_tag;
  logic [VERT_W-1:0] s1_x;
  logic [VERT_W-1:0] s2_x;
  logic [PW1-1:0]    s1_prod;
  logic [PW2-1:0]    s2_prod;
  logic [PW1-1:0]    s1_shift;
  logic [VERT_W-1:0] quo;
  logic [PW2-1:0]    rem;
  logic [PW2-1:0]    rem_fix;

  assign s1_shift = s1_prod >> SHIFT;
  assign quo = s1_shift[VERT_W-1:0];
  assign rem = PW2'(s2_x) - s2_prod;
  assign rem_fix = (rem >= PW2'(DEPTH)) ? (rem - PW2'(DEPTH)) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_tag <= in_tag;
    s1_x <= in_x;
    s1_prod <= PW1'(in_x) * PW1'(RECIP);
    s2_tag <= s1_tag;
    s2_x <= s1_x;
    s2_prod <= PW2'(quo) * PW2'(DEPTH);
    out_tag <= s2_tag;
    out_home <= rem_fix[AW-1:0];
  end

endmodule

// ----- rtl/tue_dpath.sv -----
// Datapath: corner registers, home slot table, probe address, edge slot memory,
// result count and the pending and output result registers. Depends on tue_pkg, tue_hash.
module tue_dpath import tue_pkg::*; #(
  parameter int VERTEX_BITS = 16,
  parameter int TABLE_DEPTH = 16384,
  parameter int PROBE_LIMIT = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [FIELD_W-1:0] corner_a,
  input  logic [FIELD_W-1:0] corner_b,
  input  logic [FIELD_W-1:0] corner_c,
  input  logic [FIELD_W-1:0] corner_d,
  input  logic               clear_table,
  input  tue_cmd_t           cmd,
  output tue_sts_t           sts,
  output logic               edge_valid,
  input  logic               edge_stall,
  output logic [FIELD_W-1:0] edge_first,
  output logic [FIELD_W-1:0] edge_second,
  output logic [NUM_W-1:0]   edge_number,
  output logic               status,
  output logic               last_of_item
);

  localparam int VW = (VERTEX_BITS < FIELD_W) ? VERTEX_BITS : FIELD_W;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int LIMIT = (PROBE_LIMIT < TABLE_DEPTH) ? PROBE_LIMIT : TABLE_DEPTH;
  localparam int KW = (LIMIT > 1) ? $clog2(LIMIT) : 1;
  localparam int MW = EPOCH_W + 2 * VW;
  localparam logic [AW-1:0] ADDR_LAST = AW'(TABLE_DEPTH - 1);
  localparam logic [KW-1:0] K_LAST = KW'(LIMIT - 1);
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam pair_idx_t PAIR_LAST = pair_idx_t'(NUM_PAIRS - 1);

  function automatic logic [2*VW-1:0] select_pair(input pair_idx_t idx,
                                                  input logic [VW-1:0] a,
                                                  input logic [VW-1:0] b,
                                                  input logic [VW-1:0] c,
                                                  input logic [VW-1:0] d);
    logic [2*VW-1:0] r;
    case (idx)
      3'd0: r = {a, b};
      3'd1: r = {a, c};
      3'd2: r = {a, d};
      3'd3: r = {b, c};
      3'd4: r = {b, d};
      3'd5: r = {c, d};
      default: r = {a, b};
    endcase
    return r;
  endfunction

  logic [VW-1:0]      vert_a;
  logic [VW-1:0]      vert_b;
  logic [VW-1:0]      vert_c;
  logic [VW-1:0]      vert_d;
  logic               hrun;
  pair_idx_t          hidx;
  logic [2*VW-1:0]    issue_pair;
  logic [VW-1:0]      issue_x;
  logic               h_valid;
  pair_idx_t          h_tag;
  logic [AW-1:0]      h_home;
  logic [AW-1:0]      home [NUM_PAIRS];
  pair_idx_t          pidx;
  pair_idx_t          pidx_inc;
  logic [KW-1:0]      k;
  logic [AW-1:0]      addr;
  logic [AW-1:0]      sweep_addr;
  logic [EPOCH_W-1:0] epoch;
  logic [NUM_W-1:0]   count;
  logic [2*VW-1:0]    cur_pair;
  logic [VW-1:0]      cur_p;
  logic [VW-1:0]      cur_q;
  logic [MW-1:0]      slots [TABLE_DEPTH];
  logic [MW-1:0]      rd_data;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [MW-1:0]      wr_data;
  logic [EPOCH_W-1:0] rd_epoch;
  logic [VW-1:0]      rd_first;
  logic [VW-1:0]      rd_second;
  logic               push;
  logic               move;
  logic               out_free;
  logic               pend_valid;
  logic [VW-1:0]      pend_first;
  logic [VW-1:0]      pend_second;
  logic [NUM_W-1:0]   pend_number;
  logic               pend_status;
  logic               out_valid;
  logic [VW-1:0]      out_first;
  logic [VW-1:0]      out_second;
  logic [NUM_W-1:0]   out_number;
  logic               out_status;
  logic               out_last;

  assign issue_pair = select_pair(hidx, vert_a, vert_b, vert_c, vert_d);
  assign issue_x = issue_pair[2*VW-1:VW] ^ issue_pair[VW-1:0];

  tue_hash #(
    .VERT_W(VW),
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_hash (
    .clk(clk),
    .rst(rst),
    .in_valid(hrun),
    .in_tag(hidx),
    .in_x(issue_x),
    .out_valid(h_valid),
    .out_tag(h_tag),
    .out_home(h_home)
  );

  assign pidx_inc = pidx + 3'd1;
  assign cur_pair = select_pair(pidx, vert_a, vert_b, vert_c, vert_d);
  assign cur_p = cur_pair[2*VW-1:VW];
  assign cur_q = cur_pair[VW-1:0];

  assign wr_en = cmd.sweep | cmd.insert;
  assign wr_addr = cmd.sweep ? sweep_addr : addr;
  assign wr_data = cmd.sweep ? '0 : {epoch, cur_p, cur_q};
  assign rd_epoch = rd_data[MW-1 -: EPOCH_W];
  assign rd_first = rd_data[2*VW-1:VW];
  assign rd_second = rd_data[VW-1:0];

  assign push = cmd.insert | cmd.drop;
  assign move = (push & pend_valid) | cmd.flush;
  assign out_free = ~out_valid | ~edge_stall;

  assign sts.need_sweep = clear_table && (epoch == EPOCH_MAX);
  assign sts.sweep_last = (sweep_addr == ADDR_LAST);
  assign sts.occupied = (rd_epoch == epoch);
  assign sts.match = ((rd_first == cur_p) && (rd_second == cur_q)) ||
                     ((rd_first == cur_q) && (rd_second == cur_p));
  assign sts.last_probe = (k == K_LAST);
  assign sts.last_pair = (pidx == PAIR_LAST);
  assign sts.res_ok = ~pend_valid | out_free;
  assign sts.pend_valid = pend_valid;

  assign edge_valid = out_valid;
  assign edge_first = FIELD_W'(out_first);
  assign edge_second = FIELD_W'(out_second);
  assign edge_number = out_number;
  assign status = out_status;
  assign last_of_item = out_last;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_addr] <= wr_data;
    end
    rd_data <= slots[addr];
  end

  always_ff @(posedge clk) begin
    if (h_valid) begin
      home[h_tag] <= h_home;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hrun <= 1'b0;
      hidx <= '0;
      pidx <= '0;
      k <= '0;
      addr <= '0;
      sweep_addr <= '0;
      epoch <= '0;
      count <= '0;
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        hrun <= 1'b1;
        hidx <= '0;
        if (clear_table) begin
          count <= '0;
          if (epoch != EPOCH_MAX) begin
            epoch <= epoch + EPOCH_W'(1);
          end
        end
      end else if (hrun) begin
        hidx <= hidx + 3'd1;
        if (hidx == PAIR_LAST) begin
          hrun <= 1'b0;
        end
      end
      if (cmd.sweep) begin
        if (sweep_addr == ADDR_LAST) begin
          sweep_addr <= '0;
          epoch <= EPOCH_FIRST;
        end else begin
          sweep_addr <= sweep_addr + AW'(1);
        end
      end
      if (cmd.first_pair) begin
        pidx <= '0;
        k <= '0;
        addr <= home[0];
      end else if (cmd.next_pair) begin
        pidx <= pidx_inc;
        k <= '0;
        addr <= home[pidx_inc];
      end else if (cmd.step) begin
        k <= k + KW'(1);
        addr <= (addr == ADDR_LAST) ? '0 : (addr + AW'(1));
      end
      if (cmd.insert) begin
        count <= count + NUM_W'(1);
      end
      if (edge_valid && !edge_stall) begin
        out_valid <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end
      if (push) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      vert_a <= corner_a[VW-1:0];
      vert_b <= corner_b[VW-1:0];
      vert_c <= corner_c[VW-1:0];
      vert_d <= corner_d[VW-1:0];
    end
    if (move) begin
      out_first <= pend_first;
      out_second <= pend_second;
      out_number <= pend_number;
      out_status <= pend_status;
      out_last <= cmd.flush;
    end
    if (push) begin
      pend_first <= cur_p;
      pend_second <= cur_q;
      pend_number <= cmd.insert ? count : '0;
      pend_status <= cmd.insert ? STATUS_STORED : STATUS_DROPPED;
    end
  end

  // A new result may only enter when the held one can move to the output beat.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.insert || cmd.drop || cmd.flush) |-> (!pend_valid || out_free))
    else $error("result pushed with no room in the output register");

  // An edge is only written over a slot that is empty in the current epoch.
  a_insert_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !sts.occupied)
    else $error("edge inserted over an occupied slot");

endmodule

// ----- rtl/tue_ctrl.sv -----
// Controller state machine: input handshake, table clearing sweep, hash wait,
// probe sequencing and the final flush of each item. Depends on tue_pkg.
module tue_ctrl import tue_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     tet_valid,
  output logic     tet_stall,
  input  tue_sts_t sts,
  output tue_cmd_t cmd
);

  // The home slot of the first pair is written into its table in the cycle after the hash output.
  localparam int HW = $clog2(HASH_LAT + 2);
  localparam logic [HW-1:0] HASH_DONE = HW'(HASH_LAT + 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CHECK,
    ST_FLUSH
  } state_t;

  state_t        state;
  state_t        state_next;
  logic [HW-1:0] hcnt;
  logic [HW-1:0] hcnt_next;
  logic          sweep_item;
  logic          sweep_item_next;
  logic          accept;
  logic          pair_done;

  assign tet_stall = rst || (state != ST_IDLE);
  assign accept = tet_valid && !tet_stall;

  always_comb begin
    cmd = '0;
    state_next = state;
    hcnt_next = hcnt;
    sweep_item_next = sweep_item;
    pair_done = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          sweep_item_next = 1'b0;
          hcnt_next = '0;
          state_next = sweep_item ? ST_HASH : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.accept = 1'b1;
          hcnt_next = '0;
          if (sts.need_sweep) begin
            sweep_item_next = 1'b1;
            state_next = ST_CLEAR;
          end else begin
            state_next = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        if (hcnt == HASH_DONE) begin
          cmd.first_pair = 1'b1;
          state_next = ST_READ;
        end else begin
          hcnt_next = hcnt + HW'(1);
        end
      end
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.occupied && sts.match) begin
          pair_done = 1'b1;
        end else if (!sts.occupied) begin
          if (sts.res_ok) begin
            cmd.insert = 1'b1;
            pair_done = 1'b1;
          end
        end else if (sts.last_probe) begin
          if (sts.res_ok) begin
            cmd.drop = 1'b1;
            pair_done = 1'b1;
          end
        end else begin
          cmd.step = 1'b1;
          state_next = ST_READ;
        end
        if (pair_done) begin
          if (sts.last_pair) begin
            state_next = ST_FLUSH;
          end else begin
            cmd.next_pair = 1'b1;
            state_next = ST_READ;
          end
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_valid) begin
          state_next = ST_IDLE;
        end else if (sts.res_ok) begin
          cmd.flush = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      hcnt <= '0;
      sweep_item <= 1'b0;
    end else begin
      state <= state_next;
      hcnt <= hcnt_next;
      sweep_item <= sweep_item_next;
    end
  end

  // An accepted tetrahedron always starts hashing or a clearing sweep.
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_HASH || state == ST_CLEAR))
    else $error("accepted item did not start processing");

  // No result of a finished item may remain held back once idle.
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !sts.pend_valid)
    else $error("held result left behind at end of item");

endmodule

// ----- tb/tb_tetra_unique_edge_extractor.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for tetra_unique_edge_extractor: random and directed tetrahedra,
// a hashed edge table predictor, and randomly idling tet and edge channels.
// Depends on tue_pkg and the tetra_unique_edge_extractor RTL.
module tb_tetra_unique_edge_extractor;
  import tue_pkg::*;

  localparam int VERTEX_BITS = 16;
  localparam int TABLE_DEPTH = 16384;
  localparam int PROBE_LIMIT = 16;
  localparam int RANDOM_TETS = 300;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int DRAIN_CYCLES = 400;

  typedef enum logic [1:0] {
    PAIR_PROBING,
    PAIR_NEW,
    PAIR_DROPPED,
    PAIR_SEEN
  } pair_fate_t;

  typedef struct packed {
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    logic [FIELD_W-1:0] c;
    logic [FIELD_W-1:0] d;
    logic               clr;
  } tet_beat_t;

  typedef struct packed {
    logic [FIELD_W-1:0] first;
    logic [FIELD_W-1:0] second;
    logic [NUM_W-1:0]   number;
    logic               status;
    logic               last;
  } edge_beat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               tet_valid = 1'b0;
  logic               tet_stall;
  logic [FIELD_W-1:0] corner_a = '0;
  logic [FIELD_W-1:0] corner_b = '0;
  logic [FIELD_W-1:0] corner_c = '0;
  logic [FIELD_W-1:0] corner_d = '0;
  logic               clear_table = 1'b0;
  logic               edge_valid;
  logic               edge_stall = 1'b0;
  logic [FIELD_W-1:0] edge_first;
  logic [FIELD_W-1:0] edge_second;
  logic [NUM_W-1:0]   edge_number;
  logic               status;
  logic               last_of_item;

  tet_beat_t  tets_pending[$];
  edge_beat_t edges_due[$];

  logic               slot_used [TABLE_DEPTH];
  logic [FIELD_W-1:0] slot_first [TABLE_DEPTH];
  logic [FIELD_W-1:0] slot_second [TABLE_DEPTH];
  int unsigned        edge_total;

  int          error_count = 0;
  int          tets_queued = 0;
  int          tets_taken = 0;
  int          tet_wait = 0;
  int          edge_hold = 0;
  int          idle_cycles = 0;
  logic [31:0] cyc_count = '0;

  tetra_unique_edge_extractor #(
    .VERTEX_BITS(VERTEX_BITS),
    .TABLE_DEPTH(TABLE_DEPTH),
    .PROBE_LIMIT(PROBE_LIMIT)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .tet_valid(tet_valid),
    .tet_stall(tet_stall),
    .corner_a(corner_a),
    .corner_b(corner_b),
    .corner_c(corner_c),
    .corner_d(corner_d),
    .clear_table(clear_table),
    .edge_valid(edge_valid),
    .edge_stall(edge_stall),
    .edge_first(edge_first),
    .edge_second(edge_second),
    .edge_number(edge_number),
    .status(status),
    .last_of_item(last_of_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void empty_edge_table();
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      slot_used[s] = 1'b0;
    end
    edge_total = 0;
  endfunction

  // Works out the new and dropped edges of one tetrahedron and queues them in first-seen order.
  function automatic void record_tet_edges(tet_beat_t tet);
    logic [FIELD_W-1:0] v [4];
    int                 start_size;
    int                 home;
    int                 idx;
    int                 window;
    pair_fate_t         fate;
    edge_beat_t         beat;

    v[0] = tet.a;
    v[1] = tet.b;
    v[2] = tet.c;
    v[3] = tet.d;
    if (tet.clr) begin
      empty_edge_table();
    end
    start_size = edges_due.size();
    window = (PROBE_LIMIT < TABLE_DEPTH) ? PROBE_LIMIT : TABLE_DEPTH;
    for (int i = 0; i < 4; i++) begin
      for (int j = i + 1; j < 4; j++) begin
        home = int'(v[i] ^ v[j]) % TABLE_DEPTH;
        fate = PAIR_PROBING;
        beat.first = v[i];
        beat.second = v[j];
        beat.number = '0;
        beat.status = STATUS_DROPPED;
        beat.last = 1'b0;
        for (int k = 0; k < window && fate == PAIR_PROBING; k++) begin
          idx = (home + k) % TABLE_DEPTH;
          if (!slot_used[idx]) begin
            slot_used[idx] = 1'b1;
            slot_first[idx] = v[i];
            slot_second[idx] = v[j];
            beat.number = edge_total[NUM_W-1:0];
            beat.status = STATUS_STORED;
            edge_total++;
            fate = PAIR_NEW;
          end else if ((slot_first[idx] == v[i] && slot_second[idx] == v[j]) ||
                       (slot_first[idx] == v[j] && slot_second[idx] == v[i])) begin
            fate = PAIR_SEEN;
          end
        end
        if (fate != PAIR_SEEN) begin
          edges_due.push_back(beat);
        end
      end
    end
    if (edges_due.size() > start_size) begin
      edges_due[edges_due.size()-1].last = 1'b1;
    end
  endfunction

  function automatic int draw_pause();
    if (cyc_count[10:9] == 2'b01) begin
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    if (error_count <= 100) begin
      $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
    end
  endtask

  task automatic queue_tet(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
                           logic [FIELD_W-1:0] c, logic [FIELD_W-1:0] d, logic clr);
    tet_beat_t tet;

    tet.a = a;
    tet.b = b;
    tet.c = c;
    tet.d = d;
    tet.clr = clr;
    tets_pending.push_back(tet);
    tets_queued++;
  endtask

  // Tet channel driver.
  always @(posedge clk) begin
    tet_beat_t next_tet;
    logic      fire;

    if (rst) begin
      tet_valid <= 1'b0;
      tet_wait = 0;
    end else begin
      fire = tet_valid && !tet_stall;
      if (fire) begin
        next_tet.a = corner_a;
        next_tet.b = corner_b;
        next_tet.c = corner_c;
        next_tet.d = corner_d;
        next_tet.clr = clear_table;
        record_tet_edges(next_tet);
        tets_taken++;
        tet_wait = draw_pause();
      end
      if (fire || !tet_valid) begin
        if (tet_wait > 0) begin
          tet_wait--;
          tet_valid <= 1'b0;
        end else if (tets_pending.size() > 0) begin
          next_tet = tets_pending.pop_front();
          corner_a <= next_tet.a;
          corner_b <= next_tet.b;
          corner_c <= next_tet.c;
          corner_d <= next_tet.d;
          clear_table <= next_tet.clr;
          tet_valid <= 1'b1;
        end else begin
          tet_valid <= 1'b0;
        end
      end
    end
  end

  // Edge channel monitor and checker.
  always @(posedge clk) begin
    edge_beat_t want;

    if (rst) begin
      edge_stall <= 1'b0;
      edge_hold = 0;
    end else begin
      if (edge_valid && !edge_stall) begin
        if (edges_due.size() == 0) begin
          report_mismatch("unexpected edge beat, first vertex", 32'(edge_first), 32'd0);
        end else begin
          want = edges_due.pop_front();
          if (edge_first !== want.first)
            report_mismatch("edge_first", 32'(edge_first), 32'(want.first));
          if (edge_second !== want.second)
            report_mismatch("edge_second", 32'(edge_second), 32'(want.second));
          if (edge_number !== want.number)
            report_mismatch("edge_number", 32'(edge_number), 32'(want.number));
          if (status !== want.status)
            report_mismatch("status", 32'(status), 32'(want.status));
          if (last_of_item !== want.last)
            report_mismatch("last_of_item", 32'(last_of_item), 32'(want.last));
        end
        edge_hold = draw_pause();
      end
      if (edge_hold > 0) begin
        edge_hold--;
        edge_stall <= 1'b1;
      end else begin
        edge_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cyc_count <= cyc_count + 1;
    if ((tet_valid && !tet_stall) || (edge_valid && !edge_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[tetra_unique_edge_extractor] ERROR");
      $finish;
    end
  end

  function automatic logic [FIELD_W-1:0] pick_vertex(int mode, logic [FIELD_W-1:0] cluster,
                                                     logic [FIELD_W-1:0] recent [8]);
    case (mode)
      0: return cluster | FIELD_W'($urandom_range(0, 31));
      1: return recent[$urandom_range(0, 7)];
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [FIELD_W-1:0] recent [8];
    logic [FIELD_W-1:0] cluster;
    logic [FIELD_W-1:0] v [4];
    logic [FIELD_W-1:0] base;
    int                 mode;
    int                 roll;

    empty_edge_table();

    // Extremes, both orientations, repeated corners and a tet with no new edge.
    queue_tet(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
    queue_tet(16'hFFFF, 16'h0000, 16'h0001, 16'h0002, 1'b0);
    queue_tet(16'h0005, 16'h0005, 16'h0005, 16'h0005, 1'b0);
    queue_tet(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
    queue_tet(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 1'b0);
    queue_tet(16'hEDCB, 16'hA987, 16'h6543, 16'h210F, 1'b0);
    queue_tet(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 1'b1);
    // Self loops and neighbor pairs pile up at the low home slots until the window fills.
    for (int n = 1; n <= 6; n++) begin
      base = FIELD_W'(n << 8);
      queue_tet(base, base, base ^ 16'h0001, base ^ 16'h0001, 1'b0);
    end
    queue_tet(16'h0700, 16'h0700, 16'h0700, 16'h0700, 1'b0);
    queue_tet(16'h0700, 16'h0700, 16'h0700, 16'h0700, 1'b0);
    queue_tet(16'h0701, 16'h0700, 16'h0007, 16'h0007, 1'b0);
    queue_tet(16'h0700, 16'h0700, 16'h0700, 16'h0700, 1'b1);
    queue_tet(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);

    for (int r = 0; r < 8; r++) begin
      recent[r] = FIELD_W'($urandom);
    end
    cluster = FIELD_W'($urandom) & 16'hFFE0;
    for (int t = 0; t < RANDOM_TETS; t++) begin
      if ($urandom_range(0, 19) == 0) begin
        cluster = FIELD_W'($urandom) & 16'hFFE0;
      end
      roll = $urandom_range(0, 99);
      mode = (roll < 35) ? 0 : (roll < 60) ? 1 : (roll < 90) ? 2 : 3;
      if (mode == 3) begin
        v[0] = FIELD_W'($urandom);
        v[1] = ($urandom_range(0, 1) == 1) ? v[0] : recent[$urandom_range(0, 7)];
        for (int q = 2; q < 4; q++) begin
          v[q] = ($urandom_range(0, 1) == 1) ? v[0] : v[1];
        end
      end else begin
        for (int q = 0; q < 4; q++) begin
          v[q] = pick_vertex(mode, cluster, recent);
        end
      end
      for (int q = 0; q < 4; q++) begin
        recent[$urandom_range(0, 7)] = v[q];
      end
      queue_tet(v[0], v[1], v[2], v[3], $urandom_range(0, 24) == 0);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    do begin
      @(negedge clk);
    end while (tets_taken < tets_queued || edges_due.size() > 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0 && edges_due.size() == 0) begin
      $display("[tetra_unique_edge_extractor] OK");
    end else begin
      $display("[tetra_unique_edge_extractor] ERROR");
    end
    $finish;
  end

endmodule
